### rtl/core/assert_macros.svh
// Assertion helpers used by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every rising clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (prop)) else $error(msg);

// Same-cycle implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(label, ante, cons, msg) \
	`ASSERT_CLK(label, (ante) |-> (cons), msg)

`endif

### rtl/core/lcbtm_pkg.sv
package lcbtm_pkg;

	// Field widths.
	localparam int MODE_W     = 2;
	localparam int SAMPLE_W   = 24;
	localparam int FORCE_W    = 25;
	localparam int OUT_DATA_W = 80;
	localparam int CFG_ADDR_W = 2;
	localparam int CFG_DATA_W = 24;

	// Internal widths.
	localparam int DB_W      = 23;
	localparam int BRK_W     = 24;
	localparam int TMR_W     = 16;
	localparam int SUM_W     = 29;
	localparam int SUM_MAG_W = 28;
	localparam int CNT_W     = 5;

	// Default number of samples averaged for the zero offset.
	localparam int TARE_SAMPLES_DEF = 20;

	// Register indexes on the configuration port.
	localparam logic [CFG_ADDR_W-1:0] REG_DEADBAND   = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_BREAK      = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_AUTO_START = 2'd2;
	localparam logic [CFG_ADDR_W-1:0] REG_BREAK_HOLD = 2'd3;

	// Register reset values.
	localparam logic [DB_W-1:0]  DEADBAND_RST   = 23'd75;
	localparam logic [BRK_W-1:0] BREAK_RST      = 24'd25000;
	localparam logic [TMR_W-1:0] AUTO_START_RST = 16'd5000;
	localparam logic [TMR_W-1:0] BREAK_HOLD_RST = 16'd5000;

	// Event kinds carried in tuser.
	localparam logic [MODE_W-1:0] MODE_SAMPLE = 2'd0;
	localparam logic [MODE_W-1:0] MODE_TICK   = 2'd1;
	localparam logic [MODE_W-1:0] MODE_PRESS  = 2'd2;

	typedef enum logic [1:0] {
		PH_MENU   = 2'd0,
		PH_TARE   = 2'd1,
		PH_RUN    = 2'd2,
		PH_BROKEN = 2'd3
	} phase_t;

endpackage

### rtl/core/load_cell_break_test_monitor.sv
// Break test monitor for a load cell. Each input beat is one event, its kind in s_tuser
// (sample, millisecond tick or select press) and a signed 24-bit raw conversion in s_tdata;
// every event gives exactly one result beat with the phase (menu, taring, running, broken),
// the deadbanded force, the signed peak, the latched break value, a break flag and the view
// selection. One event is taken per clock cycle when the result side keeps up; an event passes
// an input register and then a result register, and its result beat is presented once the event
// has moved into the result register, which it does not do while the result side stalls.
// The zero offset is the mean of TARE_SAMPLES samples, truncated toward zero, worked out by a
// reciprocal multiply in the cycle of the last taring sample. The user must write configuration
// through the cfg port only while no event is in flight; the block itself does not enforce it.
`include "assert_macros.svh"

module load_cell_break_test_monitor #(
	parameter int TARE_SAMPLES = lcbtm_pkg::TARE_SAMPLES_DEF
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [lcbtm_pkg::SAMPLE_W-1:0]      s_tdata,    // [23:0] sample
	input  logic [lcbtm_pkg::MODE_W-1:0]        s_tuser,    // [1:0] mode
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// [1:0] phase, [26:2] force_res, [51:27] peak, [76:52] break_value,
	// [77] break_event, [78] view_sel, [79] zero
	output logic [lcbtm_pkg::OUT_DATA_W-1:0]    m_tdata,
	input  logic                                cfg_valid,
	output logic                                cfg_ready,
	input  logic [lcbtm_pkg::CFG_ADDR_W-1:0]    cfg_addr,
	input  logic [lcbtm_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import lcbtm_pkg::*;

	// Reciprocal for the offset division: exact floor for magnitudes below 2^SUM_MAG_W.
	localparam int TareLog = $clog2(TARE_SAMPLES);
	localparam int TareShift = SUM_MAG_W + TareLog;
	localparam longint unsigned TareRecipL =
		((64'd1 << TareShift) + 64'(TARE_SAMPLES) - 64'd1) / 64'(TARE_SAMPLES);
	localparam logic [SUM_MAG_W:0] TareRecip = TareRecipL[SUM_MAG_W:0];
	localparam logic [CNT_W-1:0] TareCount = CNT_W'(TARE_SAMPLES);
	localparam int ProdW = 2 * SUM_MAG_W + 1;

	// Configuration registers.
	logic [DB_W-1:0]  deadband_q;
	logic [BRK_W-1:0] break_lvl_q;
	logic [TMR_W-1:0] auto_start_q;
	logic [TMR_W-1:0] break_hold_q;

	// Test state.
	phase_t                     phase_q, phase_d;
	logic [TMR_W-1:0]           ms_timer_q, ms_timer_d;
	logic signed [SAMPLE_W-1:0] zero_offset_q, zero_offset_d;
	logic signed [SUM_W-1:0]    tare_sum_q, tare_sum_d;
	logic [CNT_W-1:0]           tare_count_q, tare_count_d;
	logic signed [FORCE_W-1:0]  last_force_q, last_force_d;
	logic signed [FORCE_W-1:0]  peak_q, peak_d;
	logic signed [FORCE_W-1:0]  latched_q, latched_d;
	logic                       view_q, view_d;

	// Input stage and result stage.
	logic                       valid_s1;
	logic [MODE_W-1:0]          mode_s1;
	logic signed [SAMPLE_W-1:0] sample_s1;
	logic                       advance;
	logic [OUT_DATA_W-1:0]      data_s2;

	// Datapath intermediates.
	logic [TMR_W-1:0]           timer_inc;
	logic signed [SUM_W-1:0]    sum_new;
	logic [SUM_W-1:0]           sum_abs;
	logic [SUM_MAG_W-1:0]       sum_mag;
	logic [ProdW-1:0]           prod;
	logic [SAMPLE_W-1:0]        quot;
	logic [CNT_W-1:0]           count_new;
	logic signed [FORCE_W-1:0]  rel;
	logic [FORCE_W-1:0]         rel_mag;
	logic [FORCE_W-1:0]         peak_mag;
	logic                       in_deadband;
	logic signed [FORCE_W-1:0]  force_db;
	logic [FORCE_W-1:0]         force_mag;
	logic                       brk;
	logic signed [FORCE_W-1:0]  force_out;

	assign cfg_ready = 1'b1;

	// Configuration writes.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			deadband_q   <= DEADBAND_RST;
			break_lvl_q  <= BREAK_RST;
			auto_start_q <= AUTO_START_RST;
			break_hold_q <= BREAK_HOLD_RST;
		end else if (cfg_valid) begin
			case (cfg_addr)
				REG_DEADBAND:   deadband_q   <= cfg_data[DB_W-1:0];
				REG_BREAK:      break_lvl_q  <= cfg_data[BRK_W-1:0];
				REG_AUTO_START: auto_start_q <= cfg_data[TMR_W-1:0];
				REG_BREAK_HOLD: break_hold_q <= cfg_data[TMR_W-1:0];
				default:        deadband_q   <= deadband_q;
			endcase
		end
	end

	// Handshake: the input stage moves on whenever the result register is empty or being taken.
	assign advance  = valid_s1 && (!m_tvalid || m_tready);
	assign s_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			mode_s1   <= s_tuser;
			sample_s1 <= s_tdata;
		end
	end

	// Saturating millisecond timer.
	assign timer_inc = (ms_timer_q == {TMR_W{1'b1}}) ? ms_timer_q : ms_timer_q + 1'b1;

	// Taring accumulation and the truncating mean.
	assign sum_new   = tare_sum_q + SUM_W'(sample_s1);
	assign count_new = tare_count_q + 1'b1;
	assign sum_abs   = sum_new[SUM_W-1] ? SUM_W'(-sum_new) : SUM_W'(sum_new);
	assign sum_mag   = sum_abs[SUM_MAG_W-1:0];
	assign prod      = ProdW'(sum_mag) * ProdW'(TareRecip);
	assign quot      = prod[TareShift +: SAMPLE_W];

	// Relative force, deadband and magnitudes.
	assign rel         = FORCE_W'(sample_s1) - FORCE_W'(zero_offset_q);
	assign rel_mag     = rel[FORCE_W-1] ? FORCE_W'(-rel) : FORCE_W'(rel);
	assign peak_mag    = peak_q[FORCE_W-1] ? FORCE_W'(-peak_q) : FORCE_W'(peak_q);
	assign in_deadband = rel_mag < FORCE_W'(deadband_q);
	assign force_db    = in_deadband ? '0 : rel;
	assign force_mag   = in_deadband ? '0 : rel_mag;

	// Next state for the event in the input stage.
	always_comb begin
		phase_d       = phase_q;
		ms_timer_d    = ms_timer_q;
		zero_offset_d = zero_offset_q;
		tare_sum_d    = tare_sum_q;
		tare_count_d  = tare_count_q;
		last_force_d  = last_force_q;
		peak_d        = peak_q;
		latched_d     = latched_q;
		view_d        = view_q;
		brk           = 1'b0;
		case (mode_s1)
			MODE_PRESS: begin
				if (phase_q == PH_MENU || phase_q == PH_BROKEN) begin
					phase_d      = PH_TARE;
					view_d       = 1'b0;
					tare_sum_d   = '0;
					tare_count_d = '0;
					last_force_d = '0;
					peak_d       = '0;
					latched_d    = '0;
				end else if (phase_q == PH_RUN) begin
					view_d = !view_q;
				end
			end
			MODE_TICK: begin
				if (phase_q == PH_MENU) begin
					ms_timer_d = timer_inc;
					if (timer_inc >= auto_start_q) begin
						phase_d      = PH_TARE;
						view_d       = 1'b0;
						tare_sum_d   = '0;
						tare_count_d = '0;
						last_force_d = '0;
						peak_d       = '0;
						latched_d    = '0;
					end
				end else if (phase_q == PH_BROKEN) begin
					ms_timer_d = timer_inc;
					if (timer_inc >= break_hold_q) begin
						phase_d    = PH_MENU;
						ms_timer_d = '0;
					end
				end
			end
			MODE_SAMPLE: begin
				if (phase_q == PH_TARE) begin
					tare_sum_d   = sum_new;
					tare_count_d = count_new;
					if (count_new >= TareCount) begin
						zero_offset_d = sum_new[SUM_W-1] ? SAMPLE_W'(-quot) : quot;
						tare_sum_d    = '0;
						tare_count_d  = '0;
						phase_d       = PH_RUN;
					end
				end else if (phase_q == PH_RUN) begin
					last_force_d = force_db;
					if (force_mag > peak_mag) begin
						peak_d = force_db;
					end
					if (force_mag >= FORCE_W'(break_lvl_q)) begin
						latched_d  = (force_mag > peak_mag) ? force_db : peak_q;
						phase_d    = PH_BROKEN;
						ms_timer_d = '0;
						brk        = 1'b1;
					end
				end
			end
			default: begin
				phase_d = phase_q;
			end
		endcase
	end

	assign force_out = (phase_d == PH_RUN || brk) ? last_force_d : '0;

	// State update as each event moves into the result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= PH_MENU;
			ms_timer_q    <= '0;
			zero_offset_q <= '0;
			tare_sum_q    <= '0;
			tare_count_q  <= '0;
			last_force_q  <= '0;
			peak_q        <= '0;
			latched_q     <= '0;
			view_q        <= 1'b0;
		end else if (advance) begin
			phase_q       <= phase_d;
			ms_timer_q    <= ms_timer_d;
			zero_offset_q <= zero_offset_d;
			tare_sum_q    <= tare_sum_d;
			tare_count_q  <= tare_count_d;
			last_force_q  <= last_force_d;
			peak_q        <= peak_d;
			latched_q     <= latched_d;
			view_q        <= view_d;
		end
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (advance) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			data_s2 <= {1'b0, view_d, brk, latched_d, peak_d, force_out, phase_d};
		end
	end

	assign m_tdata = data_s2;

	// A break beat always reports the broken phase.
	`ASSERT_IMPL(a_break_phase, m_tvalid && m_tdata[77], m_tdata[1:0] == PH_BROKEN,
		"break beat without broken phase")
	// Force is reported only while running or on the breaking beat.
	`ASSERT_IMPL(a_force_zero, m_tvalid && m_tdata[26:2] != '0,
		m_tdata[1:0] == PH_RUN || m_tdata[77], "force reported outside a test")
	// The tare count never reaches the sample total while taring.
	`ASSERT_IMPL(a_tare_count, phase_q == PH_TARE, tare_count_q < TareCount,
		"tare count overran")
	// The graph view cannot be selected before the test is running.
	`ASSERT_IMPL(a_view_tare, phase_q == PH_TARE, !view_q, "graph view set while taring")

endmodule
